FILE: hw/rtl/huffman_code_bit_packer_macros.svh
// Assertion shorthands, clocked on clk and disabled during reset.
`ifndef HUFFMAN_CODE_BIT_PACKER_MACROS_SVH
`define HUFFMAN_CODE_BIT_PACKER_MACROS_SVH

// pre holds -> post holds in the same cycle
`define HCBP_ASSERT_NOW(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// pre holds -> post holds in the next cycle
`define HCBP_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

FILE: hw/rtl/hcbp_pkg.sv
package hcbp_pkg;

	localparam int BYTE_BITS = 8;

	localparam logic [1:0] OP_LOAD   = 2'd0;
	localparam logic [1:0] OP_ENCODE = 2'd1;
	localparam logic [1:0] OP_FLUSH  = 2'd2;

	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_END  = 1'b1;

	// control bits handed from the table stage to the packer
	typedef struct packed {
		logic valid;
		logic encode;
		logic flush;
	} stage_ctl_t;

endpackage

FILE: hw/rtl/hcbp_ram.sv
module hcbp_ram #(
	parameter int WIDTH = 38,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hw/rtl/hcbp_lookup.sv
module hcbp_lookup
	import hcbp_pkg::*;
#(
	parameter int CODE_W       = 32,
	parameter int LEN_W        = 6,
	parameter int SYMBOL_COUNT = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        op,
	input  logic [7:0]        symbol,
	input  logic [31:0]       code_word,
	input  logic [5:0]        code_length,
	input  logic              take,
	output stage_ctl_t        ctl_s1,
	output logic [CODE_W-1:0] word_s1,
	output logic [LEN_W-1:0]  len_s1
);

	localparam int AW = $clog2(SYMBOL_COUNT);

	logic                    accept;
	logic                    in_range;
	logic                    hit;
	logic [AW-1:0]           addr;
	logic [5:0]              sat_len;
	logic [31:0]             masked_word;
	logic                    load_we;
	logic [SYMBOL_COUNT-1:0] code_valid_q;
	logic [CODE_W+LEN_W-1:0] rdata;

	assign in_stall = ctl_s1.valid && !take;
	assign accept   = in_valid && !in_stall;
	assign in_range = {1'b0, symbol} < 9'(SYMBOL_COUNT);
	assign addr     = symbol[AW-1:0];
	assign hit      = in_range && code_valid_q[addr];
	assign load_we  = accept && (op == OP_LOAD) && in_range;

	assign sat_len     = (code_length > 6'(CODE_W)) ? 6'(CODE_W) : code_length;
	assign masked_word = code_word & ~(32'hFFFF_FFFF << sat_len);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_valid_q <= '0;
		end else if (load_we) begin
			code_valid_q[addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (accept) begin
			ctl_s1.valid  <= 1'b1;
			ctl_s1.encode <= (op == OP_ENCODE) && hit;
			ctl_s1.flush  <= (op == OP_FLUSH);
		end else if (take) begin
			ctl_s1.valid <= 1'b0;
		end
	end

	hcbp_ram #(
		.WIDTH(CODE_W + LEN_W),
		.DEPTH(SYMBOL_COUNT)
	) u_table (
		.clk  (clk),
		.we   (load_we),
		.waddr(addr),
		.wdata({masked_word[CODE_W-1:0], sat_len[LEN_W-1:0]}),
		.re   (accept),
		.raddr(addr),
		.rdata(rdata)
	);

	assign word_s1 = rdata[CODE_W+LEN_W-1:LEN_W];
	assign len_s1  = rdata[LEN_W-1:0];

endmodule

FILE: hw/rtl/hcbp_packer.sv
module hcbp_packer
	import hcbp_pkg::*;
#(
	parameter int CODE_W = 32,
	parameter int LEN_W  = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  stage_ctl_t        ctl_s1,
	input  logic [CODE_W-1:0] word_s1,
	input  logic [LEN_W-1:0]  len_s1,
	output logic              take,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              kind,
	output logic [7:0]        byte_value,
	output logic [2:0]        pad_bits,
	output logic              last
);

	localparam int ACC_W = CODE_W + BYTE_BITS - 1;
	localparam int CNT_W = $clog2(ACC_W + 1);

	logic [ACC_W-1:0] acc_q;
	logic [CNT_W-1:0] total_q;
	logic             rep_q;
	logic [2:0]       rep_pad_q;

	logic             out_free;
	logic             has_byte;
	logic             emit_data;
	logic             emit_rep;
	logic [CNT_W-1:0] rem;
	logic [CNT_W-1:0] after_byte;
	logic [3:0]       pad_calc;
	logic [2:0]       pad_new;
	logic [7:0]       data_byte;
	logic             data_last;

	assign out_free   = !out_valid || !out_stall;
	assign has_byte   = total_q >= CNT_W'(BYTE_BITS);
	assign emit_data  = has_byte && out_free;
	assign emit_rep   = !has_byte && rep_q && out_free;
	assign after_byte = total_q - CNT_W'(BYTE_BITS);
	assign rem        = emit_data ? after_byte : total_q;
	assign take       = ctl_s1.valid && (rem < CNT_W'(BYTE_BITS)) && (!rep_q || emit_rep);

	assign pad_calc  = 4'(BYTE_BITS) - {1'b0, rem[2:0]};
	assign pad_new   = pad_calc[2:0];
	assign data_byte = 8'(acc_q >> after_byte);
	assign data_last = (after_byte < CNT_W'(BYTE_BITS)) && !rep_q;

	always_ff @(posedge clk) begin
		if (take && ctl_s1.encode) begin
			acc_q <= ACC_W'(acc_q << len_s1) | ACC_W'(word_s1);
		end else if (take && ctl_s1.flush) begin
			acc_q <= ACC_W'(acc_q << pad_new);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q   <= '0;
			rep_q     <= 1'b0;
			rep_pad_q <= '0;
		end else begin
			if (take && ctl_s1.encode) begin
				total_q <= rem + CNT_W'(len_s1);
			end else if (take && ctl_s1.flush) begin
				total_q <= rem + CNT_W'(pad_new);
			end else begin
				total_q <= rem;
			end
			if (take && ctl_s1.flush) begin
				rep_q     <= 1'b1;
				rep_pad_q <= pad_new;
			end else if (emit_rep) begin
				rep_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (emit_data || emit_rep) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_data) begin
			kind       <= KIND_DATA;
			byte_value <= data_byte;
			pad_bits   <= '0;
			last       <= data_last;
		end else if (emit_rep) begin
			kind       <= KIND_END;
			byte_value <= '0;
			pad_bits   <= rep_pad_q;
			last       <= 1'b1;
		end
	end

endmodule

FILE: hw/rtl/huffman_code_bit_packer.sv
// Table-driven Huffman encoder with an MSB-first byte packer. Load words write a symbol's
// code and length into a code table (a RAM with registered read; entries have valid flags
// cleared at reset, so no clearing pass is needed and the block is ready right after reset).
// Encode words append the symbol's code to a bit accumulator; each full byte leaves on the
// output channel as a data word, the final one of an input word marked by last. A flush pads
// the held bits to a byte boundary, sends that byte if any, then an end report with the pad
// count. Rate: one output word per cycle through the single output port while out_stall is
// low, so an input word occupies the packer until its results have left. A new input word is
// taken in the same cycle the previous one's last byte leaves. An accepted word passes the
// table read register and the bit accumulator before its first result is registered out.
module huffman_code_bit_packer
	import hcbp_pkg::*;
#(
	parameter int MAX_CODE_LEN = 32,
	parameter int SYMBOL_COUNT = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [7:0]  symbol,
	input  logic [31:0] code_word,
	input  logic [5:0]  code_length,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        kind,
	output logic [7:0]  byte_value,
	output logic [2:0]  pad_bits,
	output logic        last
);

	localparam int CODE_W = (MAX_CODE_LEN < 32) ? MAX_CODE_LEN : 32;
	localparam int LEN_W  = $clog2(CODE_W + 1);

	stage_ctl_t        ctl_s1;
	logic [CODE_W-1:0] word_s1;
	logic [LEN_W-1:0]  len_s1;
	logic              take;

	hcbp_lookup #(
		.CODE_W      (CODE_W),
		.LEN_W       (LEN_W),
		.SYMBOL_COUNT(SYMBOL_COUNT)
	) u_lookup (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.symbol     (symbol),
		.code_word  (code_word),
		.code_length(code_length),
		.take       (take),
		.ctl_s1     (ctl_s1),
		.word_s1    (word_s1),
		.len_s1     (len_s1)
	);

	hcbp_packer #(
		.CODE_W(CODE_W),
		.LEN_W (LEN_W)
	) u_packer (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl_s1    (ctl_s1),
		.word_s1   (word_s1),
		.len_s1    (len_s1),
		.take      (take),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.kind      (kind),
		.byte_value(byte_value),
		.pad_bits  (pad_bits),
		.last      (last)
	);

endmodule

FILE: hw/rtl/hcbp_checker.sv
`include "huffman_code_bit_packer_macros.svh"

module hcbp_checker
	import hcbp_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic       kind,
	input logic [7:0] byte_value,
	input logic [2:0] pad_bits,
	input logic       last
);

	logic       prev_data_q;
	logic [7:0] prev_byte_q;
	logic [8:0] pad_mask_w;
	logic [7:0] pad_mask;

	assign pad_mask_w = (9'd1 << pad_bits) - 9'd1;
	assign pad_mask   = pad_mask_w[7:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_data_q <= 1'b0;
			prev_byte_q <= '0;
		end else if (out_valid && !out_stall) begin
			prev_data_q <= (kind == KIND_DATA);
			prev_byte_q <= byte_value;
		end
	end

	`HCBP_ASSERT_NEXT(a_valid_holds, out_valid && out_stall, out_valid, "out_valid dropped under stall")
	`HCBP_ASSERT_NEXT(a_word_holds, out_valid && out_stall, $stable(kind) && $stable(byte_value) && $stable(pad_bits) && $stable(last), "output word changed under stall")
	`HCBP_ASSERT_NOW(a_end_form, out_valid && (kind == KIND_END), last && (byte_value == 8'd0), "end report without last or with data")
	`HCBP_ASSERT_NOW(a_pad_zero, out_valid && (kind == KIND_END) && (pad_bits != 3'd0), prev_data_q && ((prev_byte_q & pad_mask) == 8'd0), "padded byte missing or pad bits not zero")

endmodule

bind huffman_code_bit_packer hcbp_checker u_hcbp_checker (.*);
